// File: design/bfaq_pkg.sv
package bfaq_pkg;

    // Store size and derived widths.
    localparam int MAX_BITS     = 65536;
    localparam int MAX_HASHES   = 16;
    localparam int KEY_W        = 64;
    localparam int BIT_COUNT_W  = 17;
    localparam int HASH_COUNT_W = 5;
    localparam int CFG_DATA_W   = 17;
    localparam int CFG_IDX_W    = 1;
    localparam int MOD_W        = $clog2(MAX_BITS + 1);
    localparam int IDX_W        = $clog2(MAX_BITS);

    // Width for comparing the configured bit count against the store size.
    localparam int CMP_W = (MOD_W > BIT_COUNT_W) ? MOD_W : BIT_COUNT_W;

    // The store is kept as rows of ROW_W bits.
    localparam int ROW_W  = 64;
    localparam int BIT_AW = $clog2(ROW_W);
    localparam int ROWS   = (MAX_BITS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // The modulo unit retires DIGIT_W dividend bits per cycle.
    localparam int DIGIT_W   = 2;
    localparam int DIV_STEPS = KEY_W / DIGIT_W;
    localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [KEY_W-1:0] MIX_CONST = 64'h9e3779b97f4a7c15;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0]    REG_BIT_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0]    REG_HASH_COUNT = 1'd1;
    localparam logic [BIT_COUNT_W-1:0]  BIT_COUNT_RST  = 17'd65536;
    localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = 5'd4;

    // Opcodes.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_MIX,
        SEQ_HASH,
        SEQ_DIV,
        SEQ_READ,
        SEQ_CHECK,
        SEQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ROW_AW-1:0] addr;
        logic [ROW_W-1:0]  wdata;
    } store_req_t;

endpackage

// File: design/bfaq_div.sv
module bfaq_div
    import bfaq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] dividend,
    input  logic [MOD_W-1:0] modulus,
    output logic             done,
    output logic [IDX_W-1:0] remainder
);

    logic [KEY_W-1:0] dvd_reg;
    logic [MOD_W-1:0] rem_reg;
    logic [MOD_W-1:0] mod_reg;
    logic [MOD_W-1:0] rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // One restoring step: bring in one dividend bit, subtract the modulus if it fits.
    function automatic logic [MOD_W-1:0] mod_step(
        input logic [MOD_W-1:0] r,
        input logic             b,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W:0] t;
        t = {r, b};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[MOD_W-1:0];
    endfunction

    // Chain of DIGIT_W steps, most significant dividend bits first.
    always_comb
    begin
        rem_next = rem_reg;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            rem_next = mod_step(rem_next, dvd_reg[KEY_W-1-i], mod_reg);
        end
    end

    // Control: step counter, busy and done flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shift register and partial remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            mod_reg <= modulus;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << DIGIT_W;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = IDX_W'(rem_reg);

    // A new start never lands on a division in progress.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("modulo unit restarted while busy");

    // A start always runs the full count.
    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && (cnt_reg == CNT_W'(DIV_STEPS - 1)))
        else $error("modulo unit did not load on start");

    // The finished remainder lies below the modulus.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < mod_reg))
        else $error("remainder not below modulus");

endmodule

// File: design/bfaq_store.sv
module bfaq_store
    import bfaq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_req_t       req,
    output logic [ROW_W-1:0] rdata,
    output logic             ready
);

    logic [ROW_W-1:0]  store_mem [ROWS];
    logic [ROW_W-1:0]  rdata_reg;
    logic              clr_active_reg;
    logic              clr_active_next;
    logic [ROW_AW-1:0] clr_addr_reg;
    logic [ROW_AW-1:0] clr_addr_next;
    logic              we;
    logic [ROW_AW-1:0] waddr;
    logic [ROW_W-1:0]  wdata;

    // Clearing pass after reset: one row per cycle.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ROW_AW'(ROWS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // Write port is shared by the clearing pass and the sequencer.
    always_comb
    begin
        we    = clr_active_reg | req.wr;
        waddr = clr_active_reg ? clr_addr_reg : req.addr;
        wdata = clr_active_reg ? '0 : req.wdata;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            rdata_reg <= store_mem[req.addr];
        end
    end

    assign rdata = rdata_reg;
    assign ready = !clr_active_reg;

endmodule

// File: design/bfaq_seq.sv
module bfaq_seq
    import bfaq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    opcode,
    input  logic [KEY_W-1:0]        key_digest,
    input  logic [MOD_W-1:0]        eff_mod,
    input  logic [HASH_COUNT_W-1:0] eff_k,
    output logic                    res_valid,
    output logic                    res_present,
    input  logic                    res_ready,
    output logic                    div_start,
    output logic [KEY_W-1:0]        div_dividend,
    output logic [MOD_W-1:0]        div_mod,
    input  logic                    div_done,
    input  logic [IDX_W-1:0]        div_index,
    output store_req_t              store_req,
    input  logic [ROW_W-1:0]        store_rdata,
    input  logic                    store_ready
);

    seq_state_t              state_reg;
    seq_state_t              state_next;
    logic                    op_reg;
    logic [KEY_W-1:0]        d_reg;
    logic [KEY_W-1:0]        base_reg;
    logic [MOD_W-1:0]        m_reg;
    logic [HASH_COUNT_W-1:0] k_reg;
    logic [HASH_COUNT_W-1:0] seed_reg;
    logic [HASH_COUNT_W-1:0] seed_inc;
    logic                    present_reg;
    logic                    accept;
    logic                    hit;
    logic [ROW_AW-1:0]       row_addr;
    logic [BIT_AW-1:0]       bit_sel;

    assign accept   = (state_reg == SEQ_IDLE) && in_valid;
    assign seed_inc = seed_reg + 1'b1;
    assign row_addr = ROW_AW'(div_index >> BIT_AW);
    assign bit_sel  = div_index[BIT_AW-1:0];
    assign hit      = store_rdata[bit_sel];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_CLEAR:
            begin
                if (store_ready)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = SEQ_MIX;
                end
            end
            SEQ_MIX:
            begin
                state_next = (k_reg == '0) ? SEQ_DONE : SEQ_HASH;
            end
            SEQ_HASH:
            begin
                state_next = SEQ_DIV;
            end
            SEQ_DIV:
            begin
                if (div_done)
                begin
                    state_next = SEQ_READ;
                end
            end
            SEQ_READ:
            begin
                state_next = SEQ_CHECK;
            end
            SEQ_CHECK:
            begin
                if ((op_reg == OP_QUERY) && !hit)
                begin
                    state_next = SEQ_DONE;
                end
                else if (seed_inc == k_reg)
                begin
                    state_next = SEQ_DONE;
                end
                else
                begin
                    state_next = SEQ_HASH;
                end
            end
            SEQ_DONE:
            begin
                if (res_ready)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Outputs per state.
    always_comb
    begin
        in_stall        = (state_reg != SEQ_IDLE);
        div_start       = 1'b0;
        res_valid       = 1'b0;
        store_req.rd    = 1'b0;
        store_req.wr    = 1'b0;
        store_req.addr  = row_addr;
        store_req.wdata = store_rdata | (ROW_W'(1) << bit_sel);
        case (state_reg)
            SEQ_HASH:
            begin
                div_start = 1'b1;
            end
            SEQ_READ:
            begin
                store_req.rd = 1'b1;
            end
            SEQ_CHECK:
            begin
                store_req.wr = (op_reg == OP_ADD);
            end
            SEQ_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign res_present  = (op_reg == OP_QUERY) && present_reg;
    assign div_dividend = d_reg ^ (base_reg + KEY_W'(seed_reg));
    assign div_mod      = m_reg;

    // Word registers: the key mix is built in two adds, then one per seed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            d_reg       <= key_digest;
            base_reg    <= (key_digest << 6) + (key_digest >> 2);
            m_reg       <= eff_mod;
            k_reg       <= eff_k;
            seed_reg    <= '0;
            present_reg <= 1'b1;
        end
        else if (state_reg == SEQ_MIX)
        begin
            base_reg <= base_reg + MIX_CONST;
        end
        else if (state_reg == SEQ_CHECK)
        begin
            seed_reg <= seed_inc;
            if ((op_reg == OP_QUERY) && !hit)
            begin
                present_reg <= 1'b0;
            end
        end
    end

    // The store is never touched while its clearing pass runs.
    a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (store_req.rd || store_req.wr) |-> store_ready)
        else $error("store accessed during clearing pass");

    // Every hashed seed is below the latched hash count.
    a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_HASH) |-> (seed_reg < k_reg))
        else $error("seed beyond hash count");

    // A query never writes the store.
    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_CHECK) && (op_reg == OP_QUERY) |-> !store_req.wr)
        else $error("query wrote the store");

endmodule

// File: design/bloom_filter_add_query_core.sv
// Bloom filter with add and query over a cleared-at-reset bit store.
// Input channel: in_valid / in_stall carries one word of opcode (add or
// query) and a 64-bit key_digest. Output channel: out_valid / out_stall
// carries one word per input, present (1 if every indexed bit was set for a
// query, always 0 for an add). A word moves at a clock edge where valid is
// high and stall is low.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 is the
// bit count, the modulus; 1 is the hash count). Write only while idle.
// Per index, the sequencer starts the shared modulo unit, which retires two
// dividend bits per cycle and hands back the remainder; then it reads the
// store row and checks the bit, writing the row back for an add. An item with
// k indexes (k is 4 at reset) holds the block until its result is taken into
// the output register, and no new item is accepted before; a query stops at
// the first clear bit.
// Reset: the store is cleared one 64-bit row per cycle, all 1024 rows, with
// in_stall held high meanwhile; configuration writes are taken as usual.
// A stalled receiver holds the result in the output register; the next word
// is still accepted and worked on, and finishes once the register drains.
module bloom_filter_add_query_core
    import bfaq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [KEY_W-1:0]      key_digest,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  present
);

    logic [BIT_COUNT_W-1:0]  bit_count_reg;
    logic [HASH_COUNT_W-1:0] hash_count_reg;
    logic [CMP_W-1:0]        bc_ext;
    logic [MOD_W-1:0]        eff_mod;
    logic [HASH_COUNT_W-1:0] eff_k;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    present_reg;
    logic                    res_valid;
    logic                    res_present;
    logic                    res_ready;
    logic                    div_start;
    logic [KEY_W-1:0]        div_dividend;
    logic [MOD_W-1:0]        div_mod;
    logic                    div_done;
    logic [IDX_W-1:0]        div_index;
    store_req_t              store_req;
    logic [ROW_W-1:0]        store_rdata;
    logic                    store_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= BIT_COUNT_RST;
            hash_count_reg <= HASH_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIT_COUNT:  bit_count_reg  <= cfg_data[BIT_COUNT_W-1:0];
                REG_HASH_COUNT: hash_count_reg <= cfg_data[HASH_COUNT_W-1:0];
                default:        bit_count_reg  <= bit_count_reg;
            endcase
        end
    end

    // Effective modulus and hash count: zero modulus acts as one, both saturate.
    always_comb
    begin
        bc_ext = CMP_W'(bit_count_reg);
        if (bc_ext == '0)
        begin
            eff_mod = MOD_W'(1);
        end
        else if (bc_ext > CMP_W'(MAX_BITS))
        begin
            eff_mod = MOD_W'(MAX_BITS);
        end
        else
        begin
            eff_mod = MOD_W'(bc_ext);
        end
        if (hash_count_reg > HASH_COUNT_W'(MAX_HASHES))
        begin
            eff_k = HASH_COUNT_W'(MAX_HASHES);
        end
        else
        begin
            eff_k = hash_count_reg;
        end
    end

    bfaq_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .key_digest   (key_digest),
        .eff_mod      (eff_mod),
        .eff_k        (eff_k),
        .res_valid    (res_valid),
        .res_present  (res_present),
        .res_ready    (res_ready),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_mod      (div_mod),
        .div_done     (div_done),
        .div_index    (div_index),
        .store_req    (store_req),
        .store_rdata  (store_rdata),
        .store_ready  (store_ready)
    );

    bfaq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .modulus   (div_mod),
        .done      (div_done),
        .remainder (div_index)
    );

    bfaq_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (store_req),
        .rdata (store_rdata),
        .ready (store_ready)
    );

    // Output register: loads when empty or draining this cycle.
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            present_reg <= res_present;
        end
    end

    assign out_valid = out_valid_reg;
    assign present   = present_reg;

endmodule
